FILE: hdl/hsfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsfc_pkg
// shared types and constants for the half/single float converter
// ----------------------------------------------------------------------------
package hsfc_pkg;

  localparam int unsigned OperandWidth = 32;

  typedef enum logic {
    FUNC_H2S = 1'b0,
    FUNC_S2H = 1'b1
  } func_t;

  typedef struct packed {
    logic [OperandWidth-1:0] operand;
    func_t                   func;
  } in_item_t;

  localparam logic [15:0] HalfInf     = 16'h7C00;
  localparam logic [15:0] HalfQnanBit = 16'h0200;
  localparam logic [7:0]  BiasDiff    = 8'd112;

endpackage : hsfc_pkg
`default_nettype wire

FILE: hdl/hsfc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsfc_if
// valid/ready channel carrying one payload item
// ----------------------------------------------------------------------------
interface hsfc_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : hsfc_if
`default_nettype wire

FILE: hdl/half_single_float_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// half_single_float_converter
// ieee binary16 <-> binary32 conversion, round to nearest even on narrowing
// ----------------------------------------------------------------------------
// Three-stage pipeline: stage 1 decodes the operand and finds the leading-zero
// count of a subnormal half or the shift of a subnormal result, stage 2 does
// the shift and forms guard/sticky bits, stage 3 rounds and packs. One item
// is accepted every cycle while stage 1 can advance. A stalled output holds the
// whole pipeline only when every stage is full, so bubbles are squeezed out.
module half_single_float_converter (
  input  wire logic clk,
  input  wire logic rst_n,
  hsfc_if.sink      in_ch,
  hsfc_if.source    out_ch
);
  import hsfc_pkg::*;

  // stage 1 -----------------------------------------------------------------
  typedef enum logic [1:0] {K_PASS, K_SUB, K_RND} kind_t;

  logic        v1_r, v2_r, v3_r;
  logic        adv1, adv2, adv3;

  kind_t       k1_r;
  logic [31:0] p1_r;      // precomputed result for pass cases / high bits
  logic [23:0] m1_r;      // significand to shift
  logic [4:0]  sh1_r;     // shift amount
  logic        dir1_r;    // 1: right shift with rounding, 0: left shift

  kind_t       k1_nxt;
  logic [31:0] p1_nxt;
  logic [23:0] m1_nxt;
  logic [4:0]  sh1_nxt;
  logic        dir1_nxt;

  logic [15:0] h;
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [31:0] f;
  logic [7:0]  be;
  logic [22:0] fm;
  logic [3:0]  lz;
  logic [8:0]  e9;

  always_comb begin
    h  = in_ch.data.operand[15:0];
    he = h[14:10];
    hm = h[9:0];
    f  = in_ch.data.operand;
    be = f[30:23];
    fm = f[22:0];
    e9 = {1'b0, be} - {1'b0, BiasDiff};
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hm[i]) lz = 4'(9 - i);
    end
    k1_nxt   = K_PASS;
    p1_nxt   = '0;
    m1_nxt   = '0;
    sh1_nxt  = '0;
    dir1_nxt = 1'b0;
    if (in_ch.data.func == FUNC_H2S) begin
      p1_nxt[31] = h[15];
      if (he == 5'd0) begin
        if (hm != '0) begin
          k1_nxt        = K_SUB;
          p1_nxt[30:23] = 8'(8'd113 - {4'd0, lz} - 8'd1);
          m1_nxt        = {14'd0, hm};
          sh1_nxt       = 5'(lz + 4'd1);
        end
      end else if (he == 5'h1F) begin
        p1_nxt[30:0] = {8'hFF, hm, 13'd0};
      end else begin
        p1_nxt[30:0] = {8'({3'd0, he} + BiasDiff), hm, 13'd0};
      end
    end else begin
      p1_nxt[15] = f[31];
      if (be == 8'hFF) begin
        p1_nxt[14:0] = 15'(HalfInf | ((fm != '0) ? HalfQnanBit : 16'd0));
      end else if (!e9[8] && e9[7:0] >= 8'd31) begin
        p1_nxt[14:0] = 15'(HalfInf);
      end else if (e9[8] || e9 == 9'd0) begin
        // subnormal half result, sh = 14 - e in 14..24
        if (!($signed(e9) < -9'sd10)) begin
          k1_nxt   = K_RND;
          dir1_nxt = 1'b1;
          m1_nxt   = {1'b1, fm};
          sh1_nxt  = 5'(9'd14 - e9);
        end
      end else begin
        k1_nxt   = K_RND;
        dir1_nxt = 1'b1;
        m1_nxt   = {1'b0, fm};
        p1_nxt[14:10] = e9[4:0];
        sh1_nxt  = 5'd13;
      end
    end
  end

  // stage 2: shift ----------------------------------------------------------
  kind_t       k2_r;
  logic [31:0] p2_r;
  logic [23:0] q2_r;
  logic        g2_r, s2_r;
  logic [23:0] q2_nxt;
  logic        g2_nxt, s2_nxt;
  logic [47:0] wide;

  always_comb begin
    wide   = {m1_r, 24'd0} >> sh1_r;
    q2_nxt = dir1_r ? wide[47:24] : 24'(m1_r << sh1_r);
    g2_nxt = wide[23];
    s2_nxt = wide[22:0] != '0;
  end

  // stage 3: round and pack -------------------------------------------------
  logic [31:0] r3_r, r3_nxt;
  logic [15:0] qh;

  always_comb begin
    qh     = p2_r[15:0] | q2_r[15:0];
    r3_nxt = p2_r;
    unique case (k2_r)
      K_SUB:   r3_nxt = {p2_r[31:23], q2_r[9:0], 13'd0};
      K_RND:   r3_nxt = {16'd0, 16'(qh + 16'(g2_r && (s2_r || qh[0])))};
      default: r3_nxt = p2_r;
    endcase
  end

  // handshake: each stage moves when the one after it is empty or moving
  assign adv3 = !v3_r || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_ch.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      k1_r   <= k1_nxt;
      p1_r   <= p1_nxt;
      m1_r   <= m1_nxt;
      sh1_r  <= sh1_nxt;
      dir1_r <= dir1_nxt;
    end
    if (adv2) begin
      k2_r <= k1_r;
      p2_r <= p1_r;
      q2_r <= q2_nxt;
      g2_r <= g2_nxt;
      s2_r <= s2_nxt;
    end
    if (adv3) r3_r <= r3_nxt;
  end

  assign out_ch.valid = v3_r;
  assign out_ch.data  = r3_r;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_ch.ready |=> v3_r && $stable(r3_r))
    else $error("result changed under stall");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_ch.ready)
    else $error("input blocked with empty first stage");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v1_r)
    else $error("accepted item lost");
`endif

endmodule : half_single_float_converter
`default_nettype wire
